// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the tag check RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define DMC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication checked on every clock while out of reset.
`define DMC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/dmc_pkg.sv =====
// Types shared by the tag check controller and datapath.
package dmc_pkg;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_CHECK = 2'b10
	} dmc_state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;   // capture a new transaction, launch the tag read
		logic check;  // compare tags, update the store, register the result
	} dmc_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic rd_miss;  // current check allocates a line
	} dmc_status_t;

endpackage

// ===== rtl/core/dmc_ram.sv =====
// Generic single-port-write, registered-read RAM.
module dmc_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/dmc_ctrl.sv =====
// Sequencer for the tag check: accept, then check and report.
`include "assert_macros.svh"

module dmc_ctrl
	import dmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  dmc_status_t status,
	output logic        busy,
	output logic        done,
	output dmc_cmd_t    cmd
);

	dmc_state_t state_q;
	logic       done_q;
	logic       alloc_q;  // last check installed a line

	assign busy      = (state_q == ST_CHECK);
	assign cmd.load  = start && !busy;
	assign cmd.check = (state_q == ST_CHECK);
	assign done      = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			alloc_q <= 1'b0;
		end else begin
			done_q  <= cmd.check;
			alloc_q <= cmd.check && status.rd_miss;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`DMC_ASSERT(a_accept_then_busy, (start && !busy) |=> (busy && !done),
		"accepted transaction did not enter check")
	`DMC_ASSERT(a_check_then_done, busy |=> (!busy && done),
		"check did not finish with a result strobe")
	`DMC_ASSERT_IMPL(a_alloc_with_done, alloc_q, done_q,
		"line allocation without a result strobe")

endmodule

// ===== rtl/core/dmc_datapath.sv =====
// Address split, valid bits, tag store and result registers.
`include "assert_macros.svh"

module dmc_datapath
	import dmc_pkg::*;
#(
	parameter int ADDR_BITS    = 32,
	parameter int OFFSET_WIDTH = 5,
	parameter int INDEX_WIDTH  = 7
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  dmc_cmd_t                                    cmd,
	output dmc_status_t                                 status,
	input  logic [ADDR_BITS-1:0]                        address,
	input  logic                                        is_write,
	output logic [OFFSET_WIDTH-1:0]                     byte_offset,
	output logic [ADDR_BITS-OFFSET_WIDTH-1:0]           block_number,
	output logic [INDEX_WIDTH-1:0]                      line_index,
	output logic [ADDR_BITS-OFFSET_WIDTH-INDEX_WIDTH-1:0] address_tag,
	output logic                                        miss,
	output logic                                        mem_read,
	output logic [OFFSET_WIDTH:0]                       mem_read_size,
	output logic                                        mem_write,
	output logic                                        mem_write_size,
	output logic                                        replacement,
	output logic [ADDR_BITS-OFFSET_WIDTH-INDEX_WIDTH-1:0] evicted_tag
);

	localparam int TAG_W     = ADDR_BITS - OFFSET_WIDTH - INDEX_WIDTH;
	localparam int NUM_LINES = 1 << INDEX_WIDTH;

	logic [ADDR_BITS-1:0]   addr_s1;
	logic                   wr_s1;
	logic [NUM_LINES-1:0]   valid_q;
	logic [TAG_W-1:0]       stored_tag;
	logic [INDEX_WIDTH-1:0] idx_in;
	logic [INDEX_WIDTH-1:0] idx_s1;
	logic [TAG_W-1:0]       tag_s1;
	logic                   line_vld;
	logic                   hit;
	logic                   rd_miss;

	assign idx_in   = address[OFFSET_WIDTH +: INDEX_WIDTH];
	assign idx_s1   = addr_s1[OFFSET_WIDTH +: INDEX_WIDTH];
	assign tag_s1   = addr_s1[ADDR_BITS-1 -: TAG_W];
	assign line_vld = valid_q[idx_s1];
	assign hit      = line_vld && (stored_tag == tag_s1);
	assign rd_miss  = !hit && !wr_s1;

	assign status.rd_miss = rd_miss;

	dmc_ram #(
		.WIDTH (TAG_W),
		.DEPTH (NUM_LINES)
	) u_tag_ram (
		.clk   (clk),
		.we    (cmd.check && rd_miss),
		.waddr (idx_s1),
		.wdata (tag_s1),
		.re    (cmd.load),
		.raddr (idx_in),
		.rdata (stored_tag)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_s1 <= address;
			wr_s1   <= is_write;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.check && rd_miss) begin
			valid_q[idx_s1] <= 1'b1;
		end
	end

	// Result registers, sampled only under the strobe.
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			byte_offset    <= addr_s1[OFFSET_WIDTH-1:0];
			block_number   <= addr_s1[ADDR_BITS-1:OFFSET_WIDTH];
			line_index     <= idx_s1;
			address_tag    <= tag_s1;
			miss           <= !hit;
			mem_read       <= rd_miss;
			mem_read_size  <= rd_miss ? {1'b1, {OFFSET_WIDTH{1'b0}}} : '0;
			mem_write      <= wr_s1;
			mem_write_size <= wr_s1;
			replacement    <= rd_miss && line_vld;
			evicted_tag    <= (rd_miss && line_vld) ? stored_tag : '0;
		end
	end

	`DMC_ASSERT(a_alloc_sets_valid, (cmd.check && rd_miss) |=> valid_q[$past(idx_s1)],
		"read miss did not mark its line valid")
	`DMC_ASSERT(a_write_keeps_valid, (cmd.check && wr_s1) |=> $stable(valid_q),
		"write access changed the valid bits")

endmodule

// ===== rtl/core/direct_mapped_cache_tag_check_core.sv =====
// Top level of the direct-mapped write-through cache tag check.
//
// Usage:
//   Input channel: drive address and is_write with start high. The transaction
//   is taken at a rising edge where start is high and busy is low.
//   Result channel: one result per transaction, shown for exactly one cycle
//   with done high. The receiver cannot stall; it must sample on done.
// Sequence: the accept edge launches the tag RAM read; the next edge
//   compares tags, updates the store and loads the result registers with done.
// busy is high for the one cycle in which the registered tag RAM read is
//   compared, so no new transaction is taken before the check; the next one can
//   be accepted in the same cycle that the previous result is shown.
// Read misses install the tag and set the line's valid bit; writes go to
//   memory (size 1) and never touch the tag store. Evicted tag is zero unless
//   a valid line is replaced.
// Reset: arst_n clears all valid bits and the sequencer at once; the tag RAM
//   holds no reset value and its output is used only for valid lines. No
//   clearing pass is needed; start may be raised the cycle after reset.
module direct_mapped_cache_tag_check_core
	import dmc_pkg::*;
#(
	parameter int ADDR_BITS    = 32,
	parameter int OFFSET_WIDTH = 5,
	parameter int INDEX_WIDTH  = 7
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	output logic                                        busy,
	input  logic [ADDR_BITS-1:0]                        address,
	input  logic                                        is_write,
	output logic                                        done,
	output logic [OFFSET_WIDTH-1:0]                     byte_offset,
	output logic [ADDR_BITS-OFFSET_WIDTH-1:0]           block_number,
	output logic [INDEX_WIDTH-1:0]                      line_index,
	output logic [ADDR_BITS-OFFSET_WIDTH-INDEX_WIDTH-1:0] address_tag,
	output logic                                        miss,
	output logic                                        mem_read,
	output logic [OFFSET_WIDTH:0]                       mem_read_size,
	output logic                                        mem_write,
	output logic                                        mem_write_size,
	output logic                                        replacement,
	output logic [ADDR_BITS-OFFSET_WIDTH-INDEX_WIDTH-1:0] evicted_tag
);

	dmc_cmd_t    cmd;
	dmc_status_t status;

	// Sequencer: owns busy and the result strobe.
	dmc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Datapath: address split, valid bits, tag RAM, result registers.
	dmc_datapath #(
		.ADDR_BITS    (ADDR_BITS),
		.OFFSET_WIDTH (OFFSET_WIDTH),
		.INDEX_WIDTH  (INDEX_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.address        (address),
		.is_write       (is_write),
		.byte_offset    (byte_offset),
		.block_number   (block_number),
		.line_index     (line_index),
		.address_tag    (address_tag),
		.miss           (miss),
		.mem_read       (mem_read),
		.mem_read_size  (mem_read_size),
		.mem_write      (mem_write),
		.mem_write_size (mem_write_size),
		.replacement    (replacement),
		.evicted_tag    (evicted_tag)
	);

endmodule

// ===== test/dmc_tag_check_checker.sv =====
// Checker for the cache tag check: predicts each lookup and compares the results.
module dmc_tag_check_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [31:0] address,
	input  logic        is_write,
	input  logic        done,
	input  logic [4:0]  byte_offset,
	input  logic [26:0] block_number,
	input  logic [6:0]  line_index,
	input  logic [19:0] address_tag,
	input  logic        miss,
	input  logic        mem_read,
	input  logic [5:0]  mem_read_size,
	input  logic        mem_write,
	input  logic        mem_write_size,
	input  logic        replacement,
	input  logic [19:0] evicted_tag,
	output int          fail_count,
	output int          outstanding
);

	localparam int OFFSET_WIDTH = 5;
	localparam int INDEX_WIDTH  = 7;
	localparam int NUM_LINES    = 1 << INDEX_WIDTH;
	localparam logic [5:0] LINE_BYTES = 6'(1 << OFFSET_WIDTH);

	typedef struct packed {
		logic [4:0]  byte_offset;
		logic [26:0] block_number;
		logic [6:0]  line_index;
		logic [19:0] address_tag;
		logic        miss;
		logic        mem_read;
		logic [5:0]  mem_read_size;
		logic        mem_write;
		logic        mem_write_size;
		logic        replacement;
		logic [19:0] evicted_tag;
	} lookup_result_t;

	// shadow tag store
	logic [NUM_LINES-1:0] shadow_valid;
	logic [19:0]          shadow_tag [NUM_LINES];

	lookup_result_t expected_lookups [$];

	// one access against the shadow store; read misses allocate
	function automatic lookup_result_t lookup_and_allocate(input logic [31:0] addr,
			input logic wr);
		lookup_result_t r;
		logic           hit;
		logic           rd_miss;
		r.byte_offset  = addr[4:0];
		r.block_number = addr[31:5];
		r.line_index   = addr[11:5];
		r.address_tag  = addr[31:12];
		hit     = shadow_valid[r.line_index] && (shadow_tag[r.line_index] == r.address_tag);
		rd_miss = !hit && !wr;
		r.miss           = !hit;
		r.mem_read       = rd_miss;
		r.mem_read_size  = rd_miss ? LINE_BYTES : 6'd0;
		r.mem_write      = wr;
		r.mem_write_size = wr;
		r.replacement    = rd_miss && shadow_valid[r.line_index];
		r.evicted_tag    = r.replacement ? shadow_tag[r.line_index] : 20'd0;
		if (rd_miss) begin
			shadow_valid[r.line_index] = 1'b1;
			shadow_tag[r.line_index]   = r.address_tag;
		end
		return r;
	endfunction

	function automatic int check_field(input string name, input logic [26:0] exp_val,
			input logic [26:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lookup_result_t e;
		int             errs;
		if (!arst_n) begin
			shadow_valid = '0;
			expected_lookups.delete();
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			errs = 0;
			if (done === 1'b1) begin
				if (expected_lookups.size() == 0) begin
					$error("result with no transaction outstanding");
					errs = 1;
				end else begin
					e = expected_lookups.pop_front();
					errs += check_field("byte_offset", 27'(e.byte_offset), 27'(byte_offset));
					errs += check_field("block_number", e.block_number, block_number);
					errs += check_field("line_index", 27'(e.line_index), 27'(line_index));
					errs += check_field("address_tag", 27'(e.address_tag), 27'(address_tag));
					errs += check_field("miss", 27'(e.miss), 27'(miss));
					errs += check_field("mem_read", 27'(e.mem_read), 27'(mem_read));
					errs += check_field("mem_read_size", 27'(e.mem_read_size),
						27'(mem_read_size));
					errs += check_field("mem_write", 27'(e.mem_write), 27'(mem_write));
					errs += check_field("mem_write_size", 27'(e.mem_write_size),
						27'(mem_write_size));
					errs += check_field("replacement", 27'(e.replacement), 27'(replacement));
					errs += check_field("evicted_tag", 27'(e.evicted_tag), 27'(evicted_tag));
				end
			end
			if (start && !busy)
				expected_lookups.push_back(lookup_and_allocate(address, is_write));
			fail_count  <= fail_count + errs;
			outstanding <= expected_lookups.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
// Top of the cache tag check testbench: clock, reset, access stimulus and verdict.
module tb_top;

	import dmc_pkg::*;

	// Slowest legal run: about 1050 transactions, each with an optional idle burst;
	// the limit leaves a wide margin over it.
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ACCESS = 1030;
	// final stretch driven back to back, no idle bursts
	localparam int BURST_TAIL    = 150;
	// slack after the last result has come back, to catch a stray strobe
	localparam int DRAIN_CYCLES  = 6;
	localparam logic ACC_READ    = 1'b0;
	localparam logic ACC_WRITE   = 1'b1;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] address;
	logic        is_write;
	logic        done;
	logic [4:0]  byte_offset;
	logic [26:0] block_number;
	logic [6:0]  line_index;
	logic [19:0] address_tag;
	logic        miss;
	logic        mem_read;
	logic [5:0]  mem_read_size;
	logic        mem_write;
	logic        mem_write_size;
	logic        replacement;
	logic [19:0] evicted_tag;

	int fail_count;
	int outstanding;
	int cycle_count = 0;

	// a handful of tags reused on a few lines so that hits, write hits and
	// evictions of valid lines come up often in the random part
	logic [19:0] hot_tags [4];

	direct_mapped_cache_tag_check_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.address        (address),
		.is_write       (is_write),
		.done           (done),
		.byte_offset    (byte_offset),
		.block_number   (block_number),
		.line_index     (line_index),
		.address_tag    (address_tag),
		.miss           (miss),
		.mem_read       (mem_read),
		.mem_read_size  (mem_read_size),
		.mem_write      (mem_write),
		.mem_write_size (mem_write_size),
		.replacement    (replacement),
		.evicted_tag    (evicted_tag)
	);

	dmc_tag_check_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.address        (address),
		.is_write       (is_write),
		.done           (done),
		.byte_offset    (byte_offset),
		.block_number   (block_number),
		.line_index     (line_index),
		.address_tag    (address_tag),
		.miss           (miss),
		.mem_read       (mem_read),
		.mem_read_size  (mem_read_size),
		.mem_write      (mem_write),
		.mem_write_size (mem_write_size),
		.replacement    (replacement),
		.evicted_tag    (evicted_tag),
		.fail_count     (fail_count),
		.outstanding    (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog: a hung handshake or a lost result ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Present one access at the current falling edge and hold it until the
	// block takes it (start high, busy low at a rising edge). Returns on the
	// falling edge after the accept so the caller may drive the next one.
	task automatic issue_access(input logic [31:0] addr, input logic wr);
		start    <= 1'b1;
		address  <= addr;
		is_write <= wr;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// tag, line and byte offset into a byte address
	function automatic logic [31:0] make_addr(input logic [19:0] tag, input logic [6:0] line,
			input logic [4:0] offs);
		return {tag, line, offs};
	endfunction

	initial begin
		logic [31:0] addr;
		logic        wr;
		int          kind;
		arst_n   = 1'b0;
		start    = 1'b0;
		address  = '0;
		is_write = ACC_READ;
		foreach (hot_tags[i])
			hot_tags[i] = 20'($urandom);
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, back to back.
		// Read miss on an invalid line, then hits at both ends of the line.
		issue_access(32'h0000_0000, ACC_READ);
		issue_access(32'h0000_001F, ACC_READ);
		// Write hit: store untouched, memory written.
		issue_access(32'h0000_0005, ACC_WRITE);
		// Write miss to a valid line with another tag: no allocate.
		issue_access(make_addr(20'h00001, 7'd0, 5'd0), ACC_WRITE);
		// Read of that line is still a miss and evicts tag zero.
		issue_access(make_addr(20'h00001, 7'd0, 5'd3), ACC_READ);
		issue_access(make_addr(20'hFFFFF, 7'd0, 5'd0), ACC_READ);
		// All-ones address on a fresh line, then hit and write hit on it.
		issue_access(32'hFFFF_FFFF, ACC_READ);
		issue_access(32'hFFFF_FFE0, ACC_READ);
		issue_access(32'hFFFF_FFFF, ACC_WRITE);
		// Write miss followed by read miss with replacement of the all-ones tag.
		issue_access(make_addr(20'h12345, 7'd127, 5'd7), ACC_WRITE);
		issue_access(make_addr(20'h12345, 7'd127, 5'd7), ACC_READ);
		// Ping-pong two tags on one line.
		issue_access(make_addr(20'hABCDE, 7'd64, 5'd16), ACC_READ);
		issue_access(make_addr(20'hABCDE, 7'd64, 5'd16), ACC_WRITE);
		issue_access(make_addr(20'h54321, 7'd64, 5'd1), ACC_READ);
		issue_access(make_addr(20'hABCDE, 7'd64, 5'd0), ACC_READ);
		// Write miss on an invalid line.
		issue_access(32'h8000_0040, ACC_WRITE);
		// Alternating bit patterns.
		issue_access(32'h5555_5555, ACC_READ);
		issue_access(32'hAAAA_AAAA, ACC_READ);
		issue_access(32'h5555_5555, ACC_WRITE);
		issue_access(32'hAAAA_AAAA, ACC_READ);

		// Random part. Half the accesses use a small set of tags on a few lines and a
		// fifth use those tags on any line, so the store sees hits, write hits and
		// valid-line evictions; the rest are fully random addresses.
		for (int n = 0; n < RANDOM_ACCESS; n++) begin
			kind = $urandom_range(0, 9);
			if (kind < 5)
				addr = make_addr(hot_tags[$urandom_range(0, 3)], 7'($urandom_range(0, 7)),
					5'($urandom));
			else if (kind < 7)
				addr = make_addr(hot_tags[$urandom_range(0, 3)], 7'($urandom), 5'($urandom));
			else
				addr = $urandom();
			wr = ($urandom_range(0, 3) == 0) ? ACC_WRITE : ACC_READ;
			issue_access(addr, wr);
			// idle bursts land on either phase of the lookup
			if (n < RANDOM_ACCESS - BURST_TAIL && $urandom_range(0, 3) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
			end
		end
		start <= 1'b0;

		// every transaction must come back; the watchdog covers a lost one
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/dmc_pkg.sv
rtl/core/dmc_ram.sv
rtl/core/dmc_ctrl.sv
rtl/core/dmc_datapath.sv
rtl/core/direct_mapped_cache_tag_check_core.sv
test/dmc_tag_check_checker.sv
test/tb_top.sv
